[rtl/dq_pkg.sv]
// Shared types, codes and constants for the double-ended queue.
`default_nettype none
package dq_pkg;

  localparam int DQ_DEPTH = 16;
  localparam logic [31:0] DQ_NO_WORD = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_CLEAR      = 3'd4,
    MODE_QUERY      = 3'd5
  } dq_mode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } dq_status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_LOAD = 2'd2
  } dq_state_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } dq_in_t;

  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic               is_empty;
    logic [4:0]         entry_count;
    logic [1:0]         status;
  } dq_out_t;

  // Control-to-output-stage bundle.
  typedef struct packed {
    logic       load;
    logic       is_empty;
    logic [4:0] entry_count;
    dq_status_t status;
  } dq_res_t;

endpackage
`default_nettype wire

[rtl/dq_store.sv]
// Entry store: one write port, two registered read ports.
`default_nettype none
module dq_store #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH,
  localparam int IW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_addr,
  input  wire logic [31:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [IW-1:0] rd_addr_f,
  input  wire logic [IW-1:0] rd_addr_b,
  output logic      [31:0]   rd_data_f,
  output logic      [31:0]   rd_data_b
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_f_r;
  logic [31:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_f_r <= mem[rd_addr_f];
      rd_data_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_f = rd_data_f_r;
  assign rd_data_b = rd_data_b_r;

endmodule
`default_nettype wire

[rtl/dq_ctrl.sv]
// Sequencer: decodes an operation, updates front index and count, drives the store.
`default_nettype none
module dq_ctrl #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire dq_pkg::dq_in_t in_data,
  input  wire logic           out_free,
  output logic                wr_en,
  output logic     [IW-1:0]   wr_addr,
  output logic     [31:0]     wr_data,
  output logic                rd_en,
  output logic     [IW-1:0]   rd_addr_f,
  output logic     [IW-1:0]   rd_addr_b,
  output dq_pkg::dq_res_t     res
);

  localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
  localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  dq_pkg::dq_state_t  state_r, state_nxt;
  dq_pkg::dq_status_t status_r, status_nxt;
  logic [IW-1:0]      first_r, first_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;

  logic [IW-1:0] first_dec, first_inc;
  logic [CW-1:0] cnt_m1;
  logic [IW:0]   tail_sum, tail_wrap, back_sum, back_wrap;
  logic [IW-1:0] tail_addr, back_addr;
  logic [CW+4:0] cnt_ext;
  logic          is_full, is_empty;

  always_comb begin
    first_dec = (first_r == '0) ? LAST_IX : first_r - 1'b1;
    first_inc = (first_r == LAST_IX) ? '0 : first_r + 1'b1;
    cnt_m1    = cnt_r - 1'b1;
    // Slot after the back entry; count is below DEPTH whenever it is used.
    tail_sum  = {1'b0, first_r} + {1'b0, cnt_r[IW-1:0]};
    tail_wrap = (tail_sum >= DEPTH_W) ? tail_sum - DEPTH_W : tail_sum;
    tail_addr = tail_wrap[IW-1:0];
    back_sum  = {1'b0, first_r} + {1'b0, cnt_m1[IW-1:0]};
    back_wrap = (back_sum >= DEPTH_W) ? back_sum - DEPTH_W : back_sum;
    back_addr = (cnt_r == '0) ? first_r : back_wrap[IW-1:0];
    is_full   = (cnt_r == FULL_CNT);
    is_empty  = (cnt_r == '0);
    cnt_ext   = {5'd0, cnt_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dq_pkg::S_IDLE;
      status_r <= dq_pkg::ST_DONE;
      first_r  <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      first_r  <= first_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    status_nxt      = status_r;
    first_nxt       = first_r;
    cnt_nxt         = cnt_r;
    in_stall        = 1'b1;
    wr_en           = 1'b0;
    wr_addr         = tail_addr;
    wr_data         = in_data.value;
    rd_en           = 1'b0;
    rd_addr_f       = first_r;
    rd_addr_b       = back_addr;
    res.load        = 1'b0;
    res.is_empty    = is_empty;
    res.entry_count = cnt_ext[4:0];
    res.status      = status_r;
    unique case (state_r)
      dq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          status_nxt = dq_pkg::ST_DONE;
          state_nxt  = dq_pkg::S_READ;
          unique case (dq_pkg::dq_mode_t'(in_data.mode))
            dq_pkg::MODE_PUSH_FRONT: begin
              if (is_full) begin
                status_nxt = dq_pkg::ST_PUSH_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = first_dec;
                first_nxt = first_dec;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            dq_pkg::MODE_PUSH_BACK: begin
              if (is_full) begin
                status_nxt = dq_pkg::ST_PUSH_FULL;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            dq_pkg::MODE_POP_FRONT: begin
              if (is_empty) begin
                status_nxt = dq_pkg::ST_POP_EMPTY;
              end else begin
                first_nxt = first_inc;
                cnt_nxt   = cnt_m1;
              end
            end
            dq_pkg::MODE_POP_BACK: begin
              if (is_empty) begin
                status_nxt = dq_pkg::ST_POP_EMPTY;
              end else begin
                cnt_nxt = cnt_m1;
              end
            end
            dq_pkg::MODE_CLEAR: begin
              first_nxt = '0;
              cnt_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      dq_pkg::S_READ: begin
        rd_en     = 1'b1;
        state_nxt = dq_pkg::S_LOAD;
      end
      dq_pkg::S_LOAD: begin
        if (out_free) begin
          res.load  = 1'b1;
          state_nxt = dq_pkg::S_IDLE;
        end
      end
      default: state_nxt = dq_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/double_ended_queue.sv]
// Top level of the bounded double-ended queue of signed 32-bit words.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+----------------------------------------
//   in_     | input     | in_valid / in_stall | dq_in_t: mode, value
//   out_    | output    | out_valid/out_stall | dq_out_t: front/back value, empty,
//           |           |                     |   entry count, status
//
// An item passes the transfer (operation decode, index update, store write), the
// store's registered two-port read of front and back, and the load of the result
// register, which waits until the output side is free. No new item is taken in
// until the result of the last one is loaded.
// Reset clears the front index, count and handshake state; the store itself is
// not cleared, since an empty queue shows no stored word.
// A stalled result holds in the output register while the next item is taken in;
// that item waits in its last cycle until the register frees.
`default_nettype none
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH,
  localparam int IW = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire dq_pkg::dq_in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output dq_pkg::dq_out_t      out_data
);

  // Store port wiring
  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr_f, rd_addr_b;
  logic [31:0]   wr_data, rd_data_f, rd_data_b;

  dq_pkg::dq_res_t res;
  logic            out_free;

  // Output register
  logic            out_valid_r, out_valid_nxt;
  dq_pkg::dq_out_t out_r, out_nxt;

  // The result register is free when empty or when its transfer completes now.
  assign out_free = !out_valid_r || !out_stall;

  dq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_free  (out_free),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_f (rd_addr_f),
    .rd_addr_b (rd_addr_b),
    .res       (res)
  );

  dq_store #(.DEPTH(DEPTH)) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_f (rd_addr_f),
    .rd_addr_b (rd_addr_b),
    .rd_data_f (rd_data_f),
    .rd_data_b (rd_data_b)
  );

  // Build the result: an empty queue shows all ones in both word fields.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    out_nxt.front_value = res.is_empty ? dq_pkg::DQ_NO_WORD : rd_data_f;
    out_nxt.back_value  = res.is_empty ? dq_pkg::DQ_NO_WORD : rd_data_b;
    out_nxt.is_empty    = res.is_empty;
    out_nxt.entry_count = res.entry_count;
    out_nxt.status      = res.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload needs no reset; load only when a new result lands.
  always_ff @(posedge clk) begin
    if (res.load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

[rtl/dq_checker.sv]
// Port-level checks for the double-ended queue, bound to the top level.
`default_nettype none
module dq_checker #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire dq_pkg::dq_out_t out_data
);

  // The five-bit count is exact only while the depth fits in it.
  localparam bit EXACT = (DEPTH < 32);
  localparam logic [4:0] FULL5 = 5'(DEPTH);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      out_data.front_value == -32'sd1 && out_data.back_value == -32'sd1)
    else $error("empty queue shows a stored word");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == dq_pkg::ST_POP_EMPTY |-> out_data.is_empty)
    else $error("pop flagged empty on a non-empty queue");

  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && EXACT && out_data.status == dq_pkg::ST_PUSH_FULL |->
      out_data.entry_count == FULL5)
    else $error("push rejected on a queue that is not full");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && EXACT && out_data.entry_count == 5'd1 |->
      out_data.front_value == out_data.back_value && !out_data.is_empty)
    else $error("single entry shows different front and back");

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

[tb/double_ended_queue_tb.sv]
// Self-checking testbench for the bounded double-ended queue.
`timescale 1ns / 100ps
`default_nettype none
module double_ended_queue_tb;

  // Mode codes that the block leaves undefined; both must act as a query.
  localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
  localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

  localparam int RANDOM_ITEMS  = 1000;
  localparam int BIAS_WINDOW   = 48;   // items per push-heavy or pop-heavy stretch
  localparam int QUIET_LIMIT   = 2000; // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES  = 10;   // idle time after the last result is checked, plus margin
  localparam int DIRECTED_ROWS = 16;
  localparam int WANT_SLOTS    = 16;   // far more than can be in flight

  localparam dq_pkg::dq_out_t EMPTY_DONE = '{front_value: dq_pkg::DQ_NO_WORD,
                                             back_value: dq_pkg::DQ_NO_WORD,
                                             is_empty: 1'b1, entry_count: 5'd0,
                                             status: dq_pkg::ST_DONE};
  localparam dq_pkg::dq_out_t EMPTY_POP  = '{front_value: dq_pkg::DQ_NO_WORD,
                                             back_value: dq_pkg::DQ_NO_WORD,
                                             is_empty: 1'b1, entry_count: 5'd0,
                                             status: dq_pkg::ST_POP_EMPTY};

  typedef struct {
    logic [2:0]      mode;
    logic [31:0]     value;
    int              reps;   // row is sent this many times, value XORed with the repeat
    bit              typed;  // expected result written in the row itself
    dq_pkg::dq_out_t want;
  } stim_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  dq_pkg::dq_in_t  in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  dq_pkg::dq_out_t out_data;

  // Percent of cycles in which the sender or the receiver holds off.
  int send_idle_pct = 31;
  int recv_idle_pct = 76;

  // Predictor state: circular word store, front index and entry count.
  logic [31:0] deque_words [dq_pkg::DQ_DEPTH];
  int          head_idx = 0;
  int          held = 0;

  // Expected results in transfer order, as a ring with running counters.
  dq_pkg::dq_out_t want_ring [WANT_SLOTS];
  int              want_wr = 0;
  int              want_rd = 0;

  stim_row_t directed_rows [DIRECTED_ROWS];
  int        row_cnt = 0;

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int full_rejects = 0;
  int empty_pops = 0;
  int peak_held = 0;

  double_ended_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the predictor and return the result it should give.
  function automatic dq_pkg::dq_out_t apply_deque_op(input dq_pkg::dq_in_t item);
    dq_pkg::dq_out_t    r;
    dq_pkg::dq_status_t st;
    st = dq_pkg::ST_DONE;
    case (item.mode)
      dq_pkg::MODE_PUSH_FRONT: begin
        if (held >= dq_pkg::DQ_DEPTH) begin
          st = dq_pkg::ST_PUSH_FULL;
        end else begin
          head_idx = (head_idx + dq_pkg::DQ_DEPTH - 1) % dq_pkg::DQ_DEPTH;
          deque_words[head_idx] = item.value;
          held++;
        end
      end
      dq_pkg::MODE_PUSH_BACK: begin
        if (held >= dq_pkg::DQ_DEPTH) begin
          st = dq_pkg::ST_PUSH_FULL;
        end else begin
          deque_words[(head_idx + held) % dq_pkg::DQ_DEPTH] = item.value;
          held++;
        end
      end
      dq_pkg::MODE_POP_FRONT: begin
        if (held == 0) begin
          st = dq_pkg::ST_POP_EMPTY;
        end else begin
          head_idx = (head_idx + 1) % dq_pkg::DQ_DEPTH;
          held--;
        end
      end
      dq_pkg::MODE_POP_BACK: begin
        if (held == 0) begin
          st = dq_pkg::ST_POP_EMPTY;
        end else begin
          held--;
        end
      end
      dq_pkg::MODE_CLEAR: begin
        held = 0;
        head_idx = 0;
      end
      default: ; // query and the undefined codes leave everything alone
    endcase
    if (st == dq_pkg::ST_PUSH_FULL) full_rejects++;
    if (st == dq_pkg::ST_POP_EMPTY) empty_pops++;
    if (held > peak_held) peak_held = held;
    r.front_value = (held != 0) ? deque_words[head_idx] : dq_pkg::DQ_NO_WORD;
    r.back_value  = (held != 0) ?
                    deque_words[(head_idx + held - 1) % dq_pkg::DQ_DEPTH] :
                    dq_pkg::DQ_NO_WORD;
    r.is_empty    = (held == 0);
    r.entry_count = 5'(held);
    r.status      = st;
    return r;
  endfunction

  task automatic add_row(input logic [2:0] mode, input logic [31:0] value, input int reps,
                         input bit typed, input dq_pkg::dq_out_t want);
    stim_row_t row;
    row.mode  = mode;
    row.value = value;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    directed_rows[row_cnt] = row;
    row_cnt++;
  endtask

  // Queue up one expected result behind the others.
  task automatic note_expected(input dq_pkg::dq_out_t want);
    want_ring[want_wr % WANT_SLOTS] = want;
    want_wr++;
  endtask

  // Hand back the oldest expected result and drop it from the ring.
  function automatic dq_pkg::dq_out_t take_expected();
    dq_pkg::dq_out_t oldest;
    oldest = want_ring[want_rd % WANT_SLOTS];
    want_rd++;
    return oldest;
  endfunction

  // Present one item, hold it until the transfer, then record what it should give.
  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_item(input dq_pkg::dq_in_t item, input bit typed,
                           input dq_pkg::dq_out_t want);
    dq_pkg::dq_out_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_deque_op(item);
    note_expected(typed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  // Boundary words four times in ten, otherwise a full random word.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Push-heavy stretches drive the queue to full, pop-heavy ones drain it.
  function automatic logic [2:0] pick_mode(input bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (r < 1) return dq_pkg::MODE_CLEAR;
    if (r < 6) return dq_pkg::MODE_QUERY;
    if (r < 8) return r[0] ? MODE_UNDEF_HI : MODE_UNDEF_LO;
    if (r < (filling ? 70 : 35)) begin
      return r[1] ? dq_pkg::MODE_PUSH_FRONT : dq_pkg::MODE_PUSH_BACK;
    end
    return r[1] ? dq_pkg::MODE_POP_FRONT : dq_pkg::MODE_POP_BACK;
  endfunction

  task automatic compare_result(input dq_pkg::dq_out_t got, input dq_pkg::dq_out_t want);
    if (got.front_value !== want.front_value) begin
      $error("front_value: expected %0d, got %0d", want.front_value, got.front_value);
      errors++;
    end
    if (got.back_value !== want.back_value) begin
      $error("back_value: expected %0d, got %0d", want.back_value, got.back_value);
      errors++;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
      errors++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      errors++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
  endtask

  // Receiver: randomly stall at the falling edge, per the current idle rate.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (want_wr == want_rd) begin
        $error("result transfer with no expectation pending");
        errors++;
      end else begin
        compare_result(out_data, take_expected());
      end
    end
  end

  // Watchdog: end the run if nothing transfers for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer in %0d cycles", QUIET_LIMIT);
    $display("double_ended_queue_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    dq_pkg::dq_in_t item;
    bit             filling;
    int             n;
    filling = 1'b1;

    // Empty-queue behavior, boundary words, undefined codes, a fill past full, two pops, then a clear.
    add_row(dq_pkg::MODE_QUERY,      32'h0,         1,  1'b1, EMPTY_DONE);
    add_row(dq_pkg::MODE_POP_FRONT,  32'h0,         1,  1'b1, EMPTY_POP);
    add_row(dq_pkg::MODE_POP_BACK,   32'hFFFF_FFFF, 1,  1'b1, EMPTY_POP);
    add_row(dq_pkg::MODE_PUSH_FRONT, 32'h7FFF_FFFF, 1,  1'b0, '0);
    add_row(dq_pkg::MODE_PUSH_BACK,  32'h8000_0000, 1,  1'b0, '0);
    add_row(MODE_UNDEF_LO,           32'h1234_5678, 1,  1'b0, '0);
    add_row(MODE_UNDEF_HI,           32'hFFFF_FFFF, 1,  1'b0, '0);
    add_row(dq_pkg::MODE_POP_FRONT,  32'h0,         1,  1'b0, '0);
    add_row(dq_pkg::MODE_POP_BACK,   32'h0,         1,  1'b1, EMPTY_DONE);
    add_row(dq_pkg::MODE_PUSH_BACK,  32'h0000_1000, 8,  1'b0, '0);
    add_row(dq_pkg::MODE_PUSH_FRONT, 32'hA5A5_0000, 8,  1'b0, '0);
    add_row(dq_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFF, 1,  1'b0, '0);
    add_row(dq_pkg::MODE_PUSH_BACK,  32'h0,         1,  1'b0, '0);
    add_row(dq_pkg::MODE_POP_FRONT,  32'h0,         1,  1'b0, '0);
    add_row(dq_pkg::MODE_POP_BACK,   32'h0,         1,  1'b0, '0);
    add_row(dq_pkg::MODE_CLEAR,      32'h0,         1,  1'b1, EMPTY_DONE);

    // Hold reset, then release it at a falling edge.
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < row_cnt; i++) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        item.mode  = directed_rows[i].mode;
        item.value = directed_rows[i].value ^ 32'(k);
        send_item(item, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random part in three thirds: slow receiver, then slow sender, then no idling.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      n = (i * 3) / RANDOM_ITEMS;
      send_idle_pct = (n == 0) ? 31 : (n == 1) ? 76 : 0;
      recv_idle_pct = (n == 0) ? 76 : (n == 1) ? 31 : 0;
      if (i % BIAS_WINDOW == 0) filling = (i == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      item.mode  = pick_mode(filling);
      item.value = pick_word();
      send_item(item, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain the remaining results, then give the block time to misbehave.
    while (want_wr != want_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d operations, checked %0d results; peak fill %0d of %0d.",
             items_sent, results_seen, peak_held, dq_pkg::DQ_DEPTH);
    $display("Pushes rejected when full: %0d, pops on an empty queue: %0d.",
             full_rejects, empty_pops);
    if (errors == 0) begin
      $display("double_ended_queue_tb OK");
    end else begin
      $display("double_ended_queue_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
